FILE: hdl/ftsm_pkg.sv
`default_nettype none
package ftsm_pkg;

   localparam int FRAGS_PER_BLOCK      = 4;
   localparam int SECTORS_PER_FRAGMENT = 2;
   localparam int SECTORS_PER_FS_BLOCK = 8;
   localparam int OFFSET_ENTRIES       = 32;

   localparam int FRAG_W   = 31;
   localparam int COUNT_W  = 16;
   localparam int IDX_W    = 5;
   localparam int VAL_W    = 16;
   localparam int SECTOR_W = 32;
   localparam int NSEC_W   = 17;
   localparam int DIV_W    = 16;
   localparam int SPT_W    = 10;
   localparam int HEAD_W   = 8;
   localparam int GEO_W    = SPT_W + HEAD_W;
   localparam int BLOCK_W  = FRAG_W;
   localparam int SET_W    = DIV_W;
   localparam int SUM_W    = 48;
   localparam int PROD_W   = COUNT_W + 5;
   localparam int TBL_AW   = $clog2(OFFSET_ENTRIES);
   localparam int LATENCY  = BLOCK_W + SET_W + 3;

   localparam logic [1:0] MODE_ROT  = 2'd0;
   localparam logic [1:0] MODE_SCSI = 2'd1;

   localparam logic [2:0] CSR_MODE = 3'd0;
   localparam logic [2:0] CSR_BPC  = 3'd1;
   localparam logic [2:0] CSR_BPRS = 3'd2;
   localparam logic [2:0] CSR_SPT  = 3'd3;
   localparam logic [2:0] CSR_HEAD = 3'd4;
   localparam logic [2:0] CSR_TPRS = 3'd5;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_MODE  = 2'd1,
      ST_INDEX = 2'd2,
      ST_OVER  = 2'd3
   } status_type;

   typedef struct packed {
      logic               valid;
      logic               func;
      logic [FRAG_W-1:0]  first_frag;
      logic [COUNT_W-1:0] frag_count;
      logic               is_write;
      logic [IDX_W-1:0]   table_index;
      logic [VAL_W-1:0]   table_value;
      logic [BLOCK_W-1:0] num;
      logic [BLOCK_W-1:0] quo;
      logic [DIV_W-1:0]   rem;
      logic [BLOCK_W-1:0] cyl;
      logic [DIV_W-1:0]   in_cyl;
   } stage_type;

endpackage
`default_nettype wire

FILE: hdl/ftsm_div_cell.sv
`default_nettype none
module ftsm_div_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ftsm_pkg::stage_type           prev_stage,
   input  wire logic [ftsm_pkg::DIV_W-1:0]    divisor,
   output      ftsm_pkg::stage_type           next_stage
);

   ftsm_pkg::stage_type              stage_ff;
   ftsm_pkg::stage_type              stage_in;
   logic [ftsm_pkg::DIV_W:0]         trial;

   // one restoring division step per cell
   always_comb begin
      stage_in = prev_stage;
      trial    = {prev_stage.rem, prev_stage.num[ftsm_pkg::BLOCK_W-1]};
      stage_in.num = {prev_stage.num[ftsm_pkg::BLOCK_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
         stage_in.rem = ftsm_pkg::DIV_W'(trial - {1'b0, divisor});
         stage_in.quo = {prev_stage.quo[ftsm_pkg::BLOCK_W-2:0], 1'b1};
      end else begin
         stage_in.rem = trial[ftsm_pkg::DIV_W-1:0];
         stage_in.quo = {prev_stage.quo[ftsm_pkg::BLOCK_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign next_stage = stage_ff;

endmodule
`default_nettype wire

FILE: hdl/ftsm_map_tail.sv
`default_nettype none
module ftsm_map_tail (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ftsm_pkg::stage_type              last_stage,
   input  wire logic [1:0]                       mapping_mode,
   input  wire logic [ftsm_pkg::GEO_W-1:0]       sectors_per_cyl,
   input  wire logic [ftsm_pkg::GEO_W-1:0]       sectors_per_set,
   output      logic                             rsp_strobe,
   output      logic [ftsm_pkg::SECTOR_W-1:0]    rsp_start_sector,
   output      logic [ftsm_pkg::NSEC_W-1:0]      rsp_sector_count,
   output      logic                             rsp_write_dir,
   output      logic [1:0]                       rsp_status
);

   logic [ftsm_pkg::VAL_W-1:0]  table_ff [ftsm_pkg::OFFSET_ENTRIES];

   logic                          a_valid_ff, a_func_ff, a_dir_ff, a_bad_ff;
   logic [ftsm_pkg::NSEC_W-1:0]   a_nsec_ff, a_nsec_in;
   logic                          a_bad_in;
   logic [ftsm_pkg::SUM_W-1:0]    a_cylb_ff, a_cylb_in, a_setb_ff, a_setb_in;
   logic [ftsm_pkg::SUM_W-1:0]    a_toff_ff, a_toff_in, a_foff_ff, a_foff_in;
   logic [ftsm_pkg::SUM_W-1:0]    a_plus_ff, a_plus_in, a_minus_ff, a_minus_in;
   logic [ftsm_pkg::PROD_W-1:0]   nsec_prod;
   logic [ftsm_pkg::BLOCK_W-1:0]  block;
   logic                          load_ok;

   logic                          b_valid_ff, b_func_ff, b_dir_ff, b_bad_ff;
   logic [ftsm_pkg::NSEC_W-1:0]   b_nsec_ff;
   logic [ftsm_pkg::SUM_W-1:0]    b_rot_ff, b_rot_in, b_plus_ff, b_plus_in, b_minus_ff;

   logic                          out_valid_ff;
   logic [ftsm_pkg::SECTOR_W-1:0] out_start_ff, out_start_in;
   logic [ftsm_pkg::NSEC_W-1:0]   out_nsec_ff, out_nsec_in;
   logic                          out_dir_ff;
   ftsm_pkg::status_type          out_status_ff, out_status_in;
   logic [ftsm_pkg::SUM_W-1:0]    diff;

   // stage a: table access, products
   always_comb begin
      load_ok   = 32'(last_stage.table_index) < ftsm_pkg::OFFSET_ENTRIES;
      block     = ftsm_pkg::BLOCK_W'(last_stage.first_frag / ftsm_pkg::FRAGS_PER_BLOCK);
      nsec_prod = ftsm_pkg::PROD_W'(last_stage.frag_count)
                  * ftsm_pkg::PROD_W'(ftsm_pkg::SECTORS_PER_FRAGMENT);
      if (nsec_prod > ftsm_pkg::PROD_W'({ftsm_pkg::NSEC_W{1'b1}})) begin
         a_nsec_in = {ftsm_pkg::NSEC_W{1'b1}};
      end else begin
         a_nsec_in = nsec_prod[ftsm_pkg::NSEC_W-1:0];
      end
      if (last_stage.func) begin
         a_bad_in = !load_ok;
      end else begin
         a_bad_in = 32'(last_stage.rem) >= ftsm_pkg::OFFSET_ENTRIES;
      end
      a_cylb_in  = ftsm_pkg::SUM_W'(sectors_per_cyl) * ftsm_pkg::SUM_W'(last_stage.cyl);
      a_setb_in  = ftsm_pkg::SUM_W'(sectors_per_set)
                   * ftsm_pkg::SUM_W'(last_stage.quo[ftsm_pkg::SET_W-1:0]);
      a_toff_in  = ftsm_pkg::SUM_W'(table_ff[last_stage.rem[ftsm_pkg::TBL_AW-1:0]]);
      a_foff_in  = ftsm_pkg::SUM_W'(last_stage.first_frag % ftsm_pkg::FRAGS_PER_BLOCK)
                   * ftsm_pkg::SUM_W'(ftsm_pkg::SECTORS_PER_FRAGMENT);
      a_plus_in  = ftsm_pkg::SUM_W'(last_stage.first_frag)
                   * ftsm_pkg::SUM_W'(ftsm_pkg::SECTORS_PER_FRAGMENT);
      a_minus_in = ftsm_pkg::SUM_W'(block - ftsm_pkg::BLOCK_W'(last_stage.in_cyl))
                   * ftsm_pkg::SUM_W'(ftsm_pkg::SECTORS_PER_FS_BLOCK);
   end

   always_ff @(posedge clock) begin
      if (last_stage.valid && last_stage.func && load_ok) begin
         table_ff[last_stage.table_index[ftsm_pkg::TBL_AW-1:0]] <= last_stage.table_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= last_stage.valid;
      end
      a_func_ff  <= last_stage.func;
      a_dir_ff   <= last_stage.is_write;
      a_bad_ff   <= a_bad_in;
      a_nsec_ff  <= a_nsec_in;
      a_cylb_ff  <= a_cylb_in;
      a_setb_ff  <= a_setb_in;
      a_toff_ff  <= a_toff_in;
      a_foff_ff  <= a_foff_in;
      a_plus_ff  <= a_plus_in;
      a_minus_ff <= a_minus_in;
   end

   // stage b: sums
   assign b_rot_in  = a_cylb_ff + a_setb_ff + a_toff_ff + a_foff_ff;
   assign b_plus_in = a_cylb_ff + a_plus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_func_ff  <= a_func_ff;
      b_dir_ff   <= a_dir_ff;
      b_bad_ff   <= a_bad_ff;
      b_nsec_ff  <= a_nsec_ff;
      b_rot_ff   <= b_rot_in;
      b_plus_ff  <= b_plus_in;
      b_minus_ff <= a_minus_ff;
   end

   // stage c: range checks and result select
   always_comb begin
      diff          = b_plus_ff - b_minus_ff;
      out_start_in  = '0;
      out_nsec_in   = b_nsec_ff;
      out_status_in = ftsm_pkg::ST_OK;
      if (b_func_ff) begin
         out_nsec_in = '0;
         if (b_bad_ff) begin
            out_status_in = ftsm_pkg::ST_INDEX;
         end
      end else if (mapping_mode == ftsm_pkg::MODE_ROT) begin
         if (b_bad_ff) begin
            out_status_in = ftsm_pkg::ST_INDEX;
         end else if (b_rot_ff[ftsm_pkg::SUM_W-1:ftsm_pkg::SECTOR_W] != '0) begin
            out_status_in = ftsm_pkg::ST_OVER;
         end else begin
            out_start_in = b_rot_ff[ftsm_pkg::SECTOR_W-1:0];
         end
      end else if (mapping_mode == ftsm_pkg::MODE_SCSI) begin
         if (b_minus_ff > b_plus_ff
             || diff[ftsm_pkg::SUM_W-1:ftsm_pkg::SECTOR_W] != '0) begin
            out_status_in = ftsm_pkg::ST_OVER;
         end else begin
            out_start_in = diff[ftsm_pkg::SECTOR_W-1:0];
         end
      end else begin
         out_status_in = ftsm_pkg::ST_MODE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= b_valid_ff;
      end
      out_start_ff  <= out_start_in;
      out_nsec_ff   <= out_nsec_in;
      out_dir_ff    <= b_dir_ff;
      out_status_ff <= out_status_in;
   end

   assign rsp_strobe       = out_valid_ff;
   assign rsp_start_sector = out_start_ff;
   assign rsp_sector_count = out_nsec_ff;
   assign rsp_write_dir    = out_dir_ff;
   assign rsp_status       = out_status_ff;

endmodule
`default_nettype wire

FILE: hdl/fragment_to_sector_mapper_top.sv
// fragment to sector mapper
// request channel: an item is taken at a rising edge with start high and
//   busy low; req_func selects a translate (0) or an offset table load (1)
// response channel: one result per item, shown for one cycle with
//   rsp_strobe high; the receiver cannot stall, so results are never held
// pipeline: 31 cells of the cylinder division, 16 cells of the rotational
//   set division, then table access, sum and range check stages
// throughput: one item every cycle while busy is low; each division cell handles one
//   quotient bit per cycle, so the cell chain sets the latency
// table loads take effect in request order, at the same stage where
//   translates read the table
// csr port: geometry registers written with csr_wr_en, no read-back;
//   write them only with no transfer in flight
// reset: synchronous, clears the pipeline and sets all registers to 1;
//   busy is high while reset is held
`default_nettype none
module fragment_to_sector_mapper_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output      logic                               busy,
   input  wire logic                               req_func,
   input  wire logic [ftsm_pkg::FRAG_W-1:0]        req_first_frag,
   input  wire logic [ftsm_pkg::COUNT_W-1:0]       req_frag_count,
   input  wire logic                               req_is_write,
   input  wire logic [ftsm_pkg::IDX_W-1:0]         req_table_index,
   input  wire logic [ftsm_pkg::VAL_W-1:0]         req_table_value,
   output      logic                               rsp_strobe,
   output      logic [ftsm_pkg::SECTOR_W-1:0]      rsp_start_sector,
   output      logic [ftsm_pkg::NSEC_W-1:0]        rsp_sector_count,
   output      logic                               rsp_write_dir,
   output      logic [1:0]                         rsp_status,
   input  wire logic                               csr_wr_en,
   input  wire logic [2:0]                         csr_index,
   input  wire logic [ftsm_pkg::DIV_W-1:0]         csr_wdata
);

   logic [1:0]                        mode_ff;
   logic [ftsm_pkg::DIV_W-1:0]        bpc_ff, bprs_ff, bpc_div, bprs_div;
   logic [ftsm_pkg::SPT_W-1:0]        spt_ff;
   logic [ftsm_pkg::HEAD_W-1:0]       head_ff, tprs_ff;
   logic [ftsm_pkg::GEO_W-1:0]        spc_ff, spc_in, sps_ff, sps_in;

   ftsm_pkg::stage_type               cyl_chain [ftsm_pkg::BLOCK_W+1];
   ftsm_pkg::stage_type               set_chain [ftsm_pkg::SET_W+1];

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ftsm_pkg::MODE_SCSI;
         bpc_ff  <= ftsm_pkg::DIV_W'(1);
         bprs_ff <= ftsm_pkg::DIV_W'(1);
         spt_ff  <= ftsm_pkg::SPT_W'(1);
         head_ff <= ftsm_pkg::HEAD_W'(1);
         tprs_ff <= ftsm_pkg::HEAD_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ftsm_pkg::CSR_MODE: mode_ff <= csr_wdata[1:0];
            ftsm_pkg::CSR_BPC:  bpc_ff  <= csr_wdata;
            ftsm_pkg::CSR_BPRS: bprs_ff <= csr_wdata;
            ftsm_pkg::CSR_SPT:  spt_ff  <= csr_wdata[ftsm_pkg::SPT_W-1:0];
            ftsm_pkg::CSR_HEAD: head_ff <= csr_wdata[ftsm_pkg::HEAD_W-1:0];
            ftsm_pkg::CSR_TPRS: tprs_ff <= csr_wdata[ftsm_pkg::HEAD_W-1:0];
            default: ;
         endcase
      end
   end

   // zero divisors count as one
   assign bpc_div  = (bpc_ff == '0) ? ftsm_pkg::DIV_W'(1) : bpc_ff;
   assign bprs_div = (bprs_ff == '0) ? ftsm_pkg::DIV_W'(1) : bprs_ff;
   assign spc_in   = ftsm_pkg::GEO_W'(spt_ff) * ftsm_pkg::GEO_W'(head_ff);
   assign sps_in   = ftsm_pkg::GEO_W'(spt_ff) * ftsm_pkg::GEO_W'(tprs_ff);

   always_ff @(posedge clock) begin
      spc_ff <= spc_in;
      sps_ff <= sps_in;
   end

   always_comb begin
      cyl_chain[0]             = '0;
      cyl_chain[0].valid       = start && !busy;
      cyl_chain[0].func        = req_func;
      cyl_chain[0].first_frag  = req_first_frag;
      cyl_chain[0].frag_count  = req_frag_count;
      cyl_chain[0].is_write    = req_is_write;
      cyl_chain[0].table_index = req_table_index;
      cyl_chain[0].table_value = req_table_value;
      cyl_chain[0].num         = ftsm_pkg::BLOCK_W'(req_first_frag
                                                    / ftsm_pkg::FRAGS_PER_BLOCK);
   end

   for (genvar i = 0; i < ftsm_pkg::BLOCK_W; i++) begin : g_cyl
      ftsm_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_stage (cyl_chain[i]),
         .divisor    (bpc_div),
         .next_stage (cyl_chain[i+1])
      );
   end

   // block within cylinder goes to the top of the second dividend
   always_comb begin
      set_chain[0]        = cyl_chain[ftsm_pkg::BLOCK_W];
      set_chain[0].cyl    = cyl_chain[ftsm_pkg::BLOCK_W].quo;
      set_chain[0].in_cyl = cyl_chain[ftsm_pkg::BLOCK_W].rem;
      set_chain[0].num    = {cyl_chain[ftsm_pkg::BLOCK_W].rem,
                             {(ftsm_pkg::BLOCK_W-ftsm_pkg::DIV_W){1'b0}}};
      set_chain[0].quo    = '0;
      set_chain[0].rem    = '0;
   end

   for (genvar j = 0; j < ftsm_pkg::SET_W; j++) begin : g_set
      ftsm_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_stage (set_chain[j]),
         .divisor    (bprs_div),
         .next_stage (set_chain[j+1])
      );
   end

   ftsm_map_tail u_tail (
      .clock            (clock),
      .reset            (reset),
      .last_stage       (set_chain[ftsm_pkg::SET_W]),
      .mapping_mode     (mode_ff),
      .sectors_per_cyl  (spc_ff),
      .sectors_per_set  (sps_ff),
      .rsp_strobe       (rsp_strobe),
      .rsp_start_sector (rsp_start_sector),
      .rsp_sector_count (rsp_sector_count),
      .rsp_write_dir    (rsp_write_dir),
      .rsp_status       (rsp_status)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(ftsm_pkg::LATENCY) rsp_strobe)
      else $error("result missing after fixed latency");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ftsm_pkg::ST_OK) |-> (rsp_start_sector == '0))
      else $error("error result with nonzero start sector");

   a_mode_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ftsm_pkg::ST_MODE)
         |-> (mode_ff != ftsm_pkg::MODE_ROT && mode_ff != ftsm_pkg::MODE_SCSI))
      else $error("mode error with supported mode");

endmodule
`default_nettype wire

FILE: tb/sv/fragment_to_sector_mapper_top_test.sv
`default_nettype none
module fragment_to_sector_mapper_top_test;
   import ftsm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CYCLE_LIMIT = 400000;
   localparam int  SETTLE      = LATENCY + 6;

   typedef struct packed {
      logic [SECTOR_W-1:0] start_sector;
      logic [NSEC_W-1:0]   sector_count;
      logic                write_dir;
      status_type          status;
   } sector_result_type;

   typedef struct packed {
      logic               func;
      logic [FRAG_W-1:0]  first_frag;
      logic [COUNT_W-1:0] frag_count;
      logic               is_write;
      logic [IDX_W-1:0]   table_index;
      logic [VAL_W-1:0]   table_value;
      logic               fixed;
      sector_result_type  known;
   } fragment_request_type;

   typedef struct {
      logic [1:0]  mode;
      logic [15:0] bpc;
      logic [15:0] bprs;
      logic [15:0] spt;
      logic [15:0] head;
      logic [15:0] tprs;
      int          items;
      bit          gaps;
   } geometry_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_func = 1'b0;
   logic [FRAG_W-1:0]  req_first_frag = '0;
   logic [COUNT_W-1:0] req_frag_count = '0;
   logic req_is_write = 1'b0;
   logic [IDX_W-1:0]   req_table_index = '0;
   logic [VAL_W-1:0]   req_table_value = '0;
   logic rsp_strobe;
   logic [SECTOR_W-1:0] rsp_start_sector;
   logic [NSEC_W-1:0]   rsp_sector_count;
   logic rsp_write_dir;
   logic [1:0] rsp_status;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [DIV_W-1:0] csr_wdata = '0;

   logic              row_fixed = 1'b0;
   sector_result_type row_known = '0;

   fragment_to_sector_mapper_top DUT (.*);

   always #6 clock = ~clock;

   // mirror of the block's registers and offset table
   logic [1:0]       geo_mode = MODE_SCSI;
   longint unsigned  geo_bpc = 1, geo_bprs = 1, geo_spt = 1, geo_head = 1, geo_tprs = 1;
   logic [VAL_W-1:0] offset_table [OFFSET_ENTRIES];
   bit               loaded [OFFSET_ENTRIES];

   sector_result_type expected_sectors[$];
   int errors = 0;
   int cycles = 0;
   int checked = 0;
   int status_seen [4];
   int loads_sent = 0;

   function automatic sector_result_type map_fragment(fragment_request_type r);
      sector_result_type res;
      longint unsigned block, bpc, cyl, cyl_base, in_cyl, bprs, rset, bis, s;
      longint unsigned plus, minus, nsec;
      res = '0;
      res.write_dir = r.is_write;
      res.status = ST_OK;
      if (r.func) begin
         offset_table[r.table_index] = r.table_value;
         return res;
      end
      block = r.first_frag / FRAGS_PER_BLOCK;
      bpc = (geo_bpc == 0) ? 1 : geo_bpc;
      cyl = block / bpc;
      cyl_base = geo_spt * geo_head * cyl;
      nsec = longint'(r.frag_count) * SECTORS_PER_FRAGMENT;
      res.sector_count = (nsec > 64'h1FFFF) ? 17'h1FFFF : nsec[NSEC_W-1:0];
      if (geo_mode == MODE_ROT) begin
         in_cyl = block - cyl * bpc;
         bprs = (geo_bprs == 0) ? 1 : geo_bprs;
         rset = in_cyl / bprs;
         bis = in_cyl - rset * bprs;
         if (bis >= OFFSET_ENTRIES) begin
            res.status = ST_INDEX;
         end else begin
            s = cyl_base + geo_spt * geo_tprs * rset + offset_table[bis]
                + (r.first_frag % FRAGS_PER_BLOCK) * SECTORS_PER_FRAGMENT;
            if (s > 64'hFFFF_FFFF) res.status = ST_OVER;
            else res.start_sector = s[SECTOR_W-1:0];
         end
      end else if (geo_mode == MODE_SCSI) begin
         plus = cyl_base + longint'(r.first_frag) * SECTORS_PER_FRAGMENT;
         minus = cyl * bpc * SECTORS_PER_FS_BLOCK;
         if (minus > plus || plus - minus > 64'hFFFF_FFFF) res.status = ST_OVER;
         else res.start_sector = SECTOR_W'(plus - minus);
      end else begin
         res.status = ST_MODE;
      end
      return res;
   endfunction

   // which table entry a translate would read, or -1 if none
   function automatic int entry_read(logic [FRAG_W-1:0] frag);
      longint unsigned block, bpc, bprs, in_cyl;
      if (geo_mode != MODE_ROT) return -1;
      block = frag / FRAGS_PER_BLOCK;
      bpc = (geo_bpc == 0) ? 1 : geo_bpc;
      bprs = (geo_bprs == 0) ? 1 : geo_bprs;
      in_cyl = block % bpc;
      if (in_cyl % bprs >= OFFSET_ENTRIES) return -1;
      return int'(in_cyl % bprs);
   endfunction

   task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got 0x%0h expected 0x%0h at cycle %0d", field, got, want, cycles);
      errors++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      fragment_request_type r;
      sector_result_type    want, pred;
      if (!reset) begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MODE: geo_mode = csr_wdata[1:0];
               CSR_BPC:  geo_bpc  = 64'(csr_wdata);
               CSR_BPRS: geo_bprs = 64'(csr_wdata);
               CSR_SPT:  geo_spt  = 64'(csr_wdata[SPT_W-1:0]);
               CSR_HEAD: geo_head = 64'(csr_wdata[HEAD_W-1:0]);
               CSR_TPRS: geo_tprs = 64'(csr_wdata[HEAD_W-1:0]);
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (expected_sectors.size() == 0) begin
               $display("unexpected transfer at cycle %0d", cycles);
               errors++;
            end else begin
               want = expected_sectors.pop_front();
               checked++;
               status_seen[want.status]++;
               if (rsp_start_sector !== want.start_sector)
                  report_mismatch("start_sector", rsp_start_sector, want.start_sector);
               if (rsp_sector_count !== want.sector_count)
                  report_mismatch("sector_count", rsp_sector_count, want.sector_count);
               if (rsp_write_dir !== want.write_dir)
                  report_mismatch("write_dir", rsp_write_dir, want.write_dir);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
            end
         end
         if (start && !busy) begin
            r = '{req_func, req_first_frag, req_frag_count, req_is_write,
                  req_table_index, req_table_value, row_fixed, row_known};
            pred = map_fragment(r);
            expected_sectors.push_back(row_fixed ? row_known : pred);
         end
      end
   end

   task automatic send_request(fragment_request_type r);
      start <= 1'b1;
      req_func <= r.func;
      req_first_frag <= r.first_frag;
      req_frag_count <= r.frag_count;
      req_is_write <= r.is_write;
      req_table_index <= r.table_index;
      req_table_value <= r.table_value;
      row_fixed <= r.fixed;
      row_known <= r.known;
      if (r.func) begin
         loaded[r.table_index] = 1'b1;
         loads_sent++;
      end
      do @(posedge clock); while (busy);
   endtask

   task automatic maybe_pause(bit gaps);
      if (gaps && $urandom_range(99) < 29) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (expected_sectors.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_geometry(geometry_phase_type p);
      logic [15:0] vals [6];
      vals = '{16'(p.mode), p.bpc, p.bprs, p.spt, p.head, p.tprs};
      for (int i = 0; i < 6; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic fragment_request_type random_request();
      fragment_request_type r;
      longint unsigned      span;
      int                   e;
      r = '0;
      r.func = ($urandom_range(99) < 20);
      span = ((geo_bpc == 0) ? 1 : geo_bpc) * FRAGS_PER_BLOCK * 3;
      if ($urandom_range(99) < 65)
         r.first_frag = FRAG_W'($urandom_range(0, (span > 2000) ? 2000 : int'(span)));
      else
         r.first_frag = FRAG_W'($urandom);
      r.frag_count = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
      r.is_write = 1'($urandom_range(1));
      r.table_index = IDX_W'($urandom);
      r.table_value = ($urandom_range(3) == 0) ? 16'($urandom_range(15)) : 16'($urandom);
      if (!r.func) begin
         e = entry_read(r.first_frag);
         if (e >= 0 && !loaded[e]) begin
            r.func = 1'b1;
            r.table_index = IDX_W'(e);
         end
      end
      return r;
   endfunction

   fragment_request_type directed_rows [] = '{
      '{1'b1, 31'd0, 16'd0, 1'b0, 5'd0, 16'd0, 1'b1, '{32'd0, 17'd0, 1'b0, ST_OK}},
      '{1'b1, 31'h7FFFFFFF, 16'hFFFF, 1'b1, 5'd31, 16'hFFFF, 1'b1,
        '{32'd0, 17'd0, 1'b1, ST_OK}},
      '{1'b1, 31'd5, 16'd3, 1'b0, 5'd1, 16'h00A5, 1'b0, '0},
      '{1'b1, 31'd0, 16'd0, 1'b1, 5'd2, 16'h5A00, 1'b0, '0},
      '{1'b1, 31'd0, 16'd0, 1'b0, 5'd3, 16'd7, 1'b0, '0},
      '{1'b1, 31'd0, 16'd0, 1'b1, 5'd16, 16'h8000, 1'b0, '0},
      '{1'b0, 31'd0, 16'd0, 1'b0, 5'd0, 16'd0, 1'b1, '{32'd0, 17'd0, 1'b0, ST_OK}},
      '{1'b0, 31'd0, 16'hFFFF, 1'b1, 5'd0, 16'd0, 1'b1,
        '{32'd0, 17'd131070, 1'b1, ST_OK}},
      '{1'b0, 31'h7FFFFFFF, 16'd1, 1'b0, 5'd31, 16'hFFFF, 1'b1,
        '{32'd536870917, 17'd2, 1'b0, ST_OK}},
      '{1'b0, 31'd1, 16'd1, 1'b1, 5'd0, 16'd0, 1'b0, '0},
      '{1'b0, 31'd3, 16'd2, 1'b0, 5'd0, 16'd0, 1'b0, '0},
      '{1'b0, 31'd4, 16'h8000, 1'b1, 5'd0, 16'd0, 1'b0, '0},
      '{1'b0, 31'h40000000, 16'h7FFF, 1'b0, 5'd0, 16'd0, 1'b0, '0},
      '{1'b0, 31'h2AAAAAAA, 16'h5555, 1'b1, 5'd10, 16'h5555, 1'b0, '0},
      '{1'b0, 31'h55555555, 16'hAAAA, 1'b0, 5'd21, 16'hAAAA, 1'b0, '0}
   };

   geometry_phase_type phases [] = '{
      '{2'd0, 16'd16, 16'd8, 16'd32, 16'd4, 16'd2, 60, 1'b1},
      '{2'd0, 16'd200, 16'd64, 16'd63, 16'd16, 16'd8, 70, 1'b1},
      '{2'd1, 16'hFFFF, 16'd1, 16'd1023, 16'd255, 16'd1, 60, 1'b1},
      '{2'd0, 16'd0, 16'd0, 16'd1023, 16'd255, 16'd255, 60, 1'b1},
      '{2'd2, 16'd5, 16'd3, 16'd9, 16'd2, 16'd1, 40, 1'b1},
      '{2'd3, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1, 30, 1'b1},
      '{2'd1, 16'd100, 16'd1, 16'd17, 16'd4, 16'd1, 60, 1'b1},
      '{2'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1, 60, 1'b1},
      '{2'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 90, 1'b0},
      '{2'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 40, 1'b1}
   };

   initial begin
      for (int i = 0; i < OFFSET_ENTRIES; i++) begin
         offset_table[i] = '0;
         loaded[i] = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         maybe_pause(1'b1);
         send_request(directed_rows[i]);
      end
      drain();
      foreach (phases[p]) begin
         write_geometry(phases[p]);
         for (int n = 0; n < phases[p].items; n++) begin
            maybe_pause(phases[p].gaps);
            send_request(random_request());
         end
         drain();
      end
      $display("covered %0d transfers (%0d table loads) over %0d geometry settings",
               checked, loads_sent, phases.size() + 1);
      $display("status mix: ok %0d, bad mode %0d, index %0d, overflow %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (errors == 0 && expected_sectors.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire
